/* src/msie_pkg.sv */
// Shared types and constants for the MIPS subset instruction executor.
// No dependencies; imported by msie_exec and mips_subset_instruction_executor.
package msie_pkg;

   localparam int NUM_REGS = 32;
   localparam int REG_IDX_W = 5;
   localparam int WORD_W = 32;
   localparam logic [WORD_W-1:0] PC_STEP = 32'd4;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_AND  = 4'd2,
      OP_OR   = 4'd3,
      OP_LW   = 4'd4,
      OP_SW   = 4'd5,
      OP_ADDI = 4'd6,
      OP_BEQ  = 4'd7,
      OP_BNE  = 4'd8
   } op_type;

   typedef struct packed {
      logic [3:0]           operation;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src_a;
      logic [REG_IDX_W-1:0] src_b;
      logic signed [15:0]   immediate;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]        pc_after;
      logic                     reg_write;
      logic [REG_IDX_W-1:0]     reg_index;
      logic signed [WORD_W-1:0] reg_value;
      logic                     mem_write;
      logic [REG_IDX_W-1:0]     mem_index;
      logic                     branch_taken;
   } rsp_type;

   typedef struct packed {
      logic is_load;
      logic is_store;
   } ctl_type;

endpackage

/* src/msie_exec.sv */
// Execute logic: ALU, memory word index reduction, branch resolution and next PC.
// Purely combinational; depends on msie_pkg.
module msie_exec import msie_pkg::*; #(
   parameter int MEM_WORDS = 32,
   localparam int ADDR_W = $clog2(MEM_WORDS)
) (
   input  req_type           item,
   input  logic [WORD_W-1:0] pc,
   input  logic [WORD_W-1:0] opa,
   input  logic [WORD_W-1:0] opb,
   output logic [ADDR_W-1:0] mem_addr,
   output rsp_type           res,
   output ctl_type           ctl
);

   localparam int ACC_W = ADDR_W + 2;
   localparam logic [ACC_W-1:0] MOD_ONE = ACC_W'(MEM_WORDS);
   localparam logic [ACC_W-1:0] MOD_TWO = ACC_W'(2 * MEM_WORDS);

   typedef logic [3:0][255:0][ADDR_W-1:0] tab_type;

   // Residue of each byte lane at its weight: (j * 2^(8i)) mod MEM_WORDS.
   function automatic tab_type build_tab();
      tab_type     t;
      int unsigned weight;
      int unsigned i;
      int unsigned j;
      for (i = 0; i < 4; i++) begin
         weight = (32'd1 << (8 * i)) % MEM_WORDS;
         for (j = 0; j < 256; j++) begin
            t[i][j] = ADDR_W'((j * weight) % MEM_WORDS);
         end
      end
      return t;
   endfunction

   localparam tab_type MOD_TAB = build_tab();

   logic [WORD_W-1:0] imm32;
   logic [WORD_W-1:0] sum;
   logic [ACC_W-1:0]  acc;
   logic [ACC_W-1:0]  red1;
   logic [ACC_W-1:0]  red2;
   logic              taken;

   assign imm32 = {{16{item.immediate[15]}}, item.immediate};
   assign sum   = opa + imm32;

   // Word index: add the byte-lane residues, then at most two corrections.
   always_comb begin
      acc = ACC_W'(MOD_TAB[0][sum[7:0]]) + ACC_W'(MOD_TAB[1][sum[15:8]])
          + ACC_W'(MOD_TAB[2][sum[23:16]]) + ACC_W'(MOD_TAB[3][sum[31:24]]);
      red1 = (acc >= MOD_TWO) ? acc - MOD_TWO : acc;
      red2 = (red1 >= MOD_ONE) ? red1 - MOD_ONE : red1;
      mem_addr = red2[ADDR_W-1:0];
   end

   always_comb begin
      res = '0;
      ctl = '0;
      taken = 1'b0;
      res.pc_after = pc + PC_STEP;
      unique case (item.operation)
         OP_ADD: begin
            res.reg_write = 1'b1;
            res.reg_index = item.dest_reg;
            res.reg_value = opa + opb;
         end
         OP_SUB: begin
            res.reg_write = 1'b1;
            res.reg_index = item.dest_reg;
            res.reg_value = opa - opb;
         end
         OP_AND: begin
            res.reg_write = 1'b1;
            res.reg_index = item.dest_reg;
            res.reg_value = opa & opb;
         end
         OP_OR: begin
            res.reg_write = 1'b1;
            res.reg_index = item.dest_reg;
            res.reg_value = opa | opb;
         end
         OP_LW: begin
            // load data joins in the result stage
            res.reg_write = 1'b1;
            res.reg_index = item.src_b;
            res.mem_index = REG_IDX_W'(mem_addr);
            ctl.is_load = 1'b1;
         end
         OP_SW: begin
            res.mem_write = 1'b1;
            res.mem_index = REG_IDX_W'(mem_addr);
            ctl.is_store = 1'b1;
         end
         OP_ADDI: begin
            res.reg_write = 1'b1;
            res.reg_index = item.src_b;
            res.reg_value = sum;
         end
         OP_BEQ: taken = (opa == opb);
         OP_BNE: taken = (opa != opb);
         default: ;
      endcase
      if (taken) begin
         res.pc_after = pc + {imm32[WORD_W-3:0], 2'b00};
      end
      res.branch_taken = taken;
   end

endmodule

/* src/mips_subset_instruction_executor.sv */
// Top level of the MIPS subset instruction executor: register file, data memory,
// PC and the two-stage transfer pipeline. Depends on msie_pkg and msie_exec.
//
// Executes one decoded instruction (add, sub, and, or, lw, sw, addi, beq, bne)
// per clock, sustained, unless rsp_stall or the clearing pass holds the flow. The
// transfer edge reads the 32-entry register file into the input stage, and the
// edge on which the input stage advances lands execution with the data memory
// read in the result register. Results of older instructions, loads included,
// are forwarded so dependent instructions still issue every cycle while nothing
// stalls. After reset the data memory is zeroed by a clearing pass over every
// word, during which req_stall is high. Word indices are reduced modulo
// MEM_WORDS (2 to 65536).
module mips_subset_instruction_executor import msie_pkg::*; #(
   parameter int MEM_WORDS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(MEM_WORDS);
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MEM_WORDS - 1);

   // storage
   logic [WORD_W-1:0]   rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;
   logic [WORD_W-1:0]   dm_mem [MEM_WORDS];

   // handshake
   logic req_accept;
   logic s2_take;
   logic s1_adv;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_req_ff;
   logic [WORD_W-1:0] rda_ff, rdb_ff;
   logic              vlda_ff, vldb_ff;
   logic              bypa_ff, bypb_ff;
   logic [WORD_W-1:0] wdat_ff;

   // result stage
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_fresh_ff;
   rsp_type           s2_res_ff;
   logic              s2_load_ff;
   logic [WORD_W-1:0] mem_rd_ff;
   logic [WORD_W-1:0] s2_value;

   logic [WORD_W-1:0] pc_ff, pc_in;

   // clearing pass
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_idx_ff;

   // write ports
   logic                 rf_we;
   logic [REG_IDX_W-1:0] rf_widx;
   logic [WORD_W-1:0]    rf_wdata;
   logic                 dm_we;
   logic [ADDR_W-1:0]    dm_waddr;
   logic [WORD_W-1:0]    dm_wdata;

   // execute
   logic [WORD_W-1:0] opa, opb;
   logic [ADDR_W-1:0] ex_addr;
   rsp_type           ex_res;
   ctl_type           ex_ctl;

   assign s2_take    = s2_valid_ff && !rsp_stall;
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || s2_take);
   assign req_stall  = clr_busy_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !s2_take);
   assign pc_in       = s1_adv ? ex_res.pc_after : pc_ff;

   assign s2_value = s2_load_ff ? mem_rd_ff : WORD_W'(s2_res_ff.reg_value);

   // register file write happens in the first cycle an item sits in the result stage
   assign rf_we    = s2_valid_ff && s2_fresh_ff && s2_res_ff.reg_write;
   assign rf_widx  = s2_res_ff.reg_index;
   assign rf_wdata = s2_value;

   assign dm_we    = clr_busy_ff || (s1_adv && ex_ctl.is_store);
   assign dm_waddr = clr_busy_ff ? clr_idx_ff : ex_addr;
   assign dm_wdata = clr_busy_ff ? '0 : opb;

   // Operand select: newest older write first (result stage), then the write
   // that landed on the capture edge, then the stored value.
   always_comb begin
      opa = vlda_ff ? rda_ff : '0;
      if (bypa_ff) begin
         opa = wdat_ff;
      end
      if (s2_valid_ff && s2_res_ff.reg_write && s2_res_ff.reg_index == s1_req_ff.src_a) begin
         opa = s2_value;
      end
      opb = vldb_ff ? rdb_ff : '0;
      if (bypb_ff) begin
         opb = wdat_ff;
      end
      if (s2_valid_ff && s2_res_ff.reg_write && s2_res_ff.reg_index == s1_req_ff.src_b) begin
         opb = s2_value;
      end
   end

   msie_exec #(
      .MEM_WORDS(MEM_WORDS)
   ) u_exec (
      .item    (s1_req_ff),
      .pc      (pc_ff),
      .opa     (opa),
      .opb     (opb),
      .mem_addr(ex_addr),
      .res     (ex_res),
      .ctl     (ex_ctl)
   );

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_widx] <= rf_wdata;
      end
      if (req_accept) begin
         rda_ff <= rf_mem[req_data.src_a];
         rdb_ff <= rf_mem[req_data.src_b];
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_waddr] <= dm_wdata;
      end
      if (s1_adv) begin
         mem_rd_ff <= dm_mem[ex_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
         vlda_ff   <= rf_vld_ff[req_data.src_a];
         vldb_ff   <= rf_vld_ff[req_data.src_b];
         bypa_ff   <= rf_we && (rf_widx == req_data.src_a);
         bypb_ff   <= rf_we && (rf_widx == req_data.src_b);
         wdat_ff   <= rf_wdata;
      end
      if (s1_adv) begin
         s2_res_ff  <= ex_res;
         s2_load_ff <= ex_ctl.is_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_fresh_ff <= 1'b0;
         pc_ff       <= '0;
         rf_vld_ff   <= '0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_fresh_ff <= s1_adv;
         pc_ff       <= pc_in;
         if (rf_we) begin
            rf_vld_ff[rf_widx] <= 1'b1;
         end
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_WORD) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_data = s2_res_ff;
      rsp_data.reg_value = s2_value;
   end
   assign rsp_valid = s2_valid_ff;

   a_exec_lands: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff && s2_fresh_ff)
      else $error("executed item did not reach the result stage");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline busy during memory clearing pass");

   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      (!s1_adv) |=> $stable(pc_ff))
      else $error("PC moved without an executed instruction");

   a_load_write: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_fresh_ff && s2_load_ff) |-> (rf_we && rf_wdata == mem_rd_ff))
      else $error("load result not written to register file");

endmodule
